@@ hw/rtl/psd_pkg.sv @@
// Shared types and constants of the pixel stream decimator.
package psd_pkg;

    localparam int CFG_W   = 13;
    localparam int IDX_W   = 8;
    localparam int WORD_W  = 32;
    localparam int NCH_MAX = 8;

    localparam logic [IDX_W-1:0] REG_IN_HEIGHT  = 8'd0;
    localparam logic [IDX_W-1:0] REG_IN_WIDTH   = 8'd1;
    localparam logic [IDX_W-1:0] REG_OUT_HEIGHT = 8'd2;
    localparam logic [IDX_W-1:0] REG_OUT_WIDTH  = 8'd3;

    typedef struct packed {
        logic [CFG_W-1:0] in_h;
        logic [CFG_W-1:0] in_w;
        logic [CFG_W-1:0] out_h;
        logic [CFG_W-1:0] out_w;
    } t_sizes;

    typedef struct packed {
        logic [WORD_W-1:0] chan_in_0;
        logic [WORD_W-1:0] chan_in_1;
        logic [WORD_W-1:0] chan_in_2;
        logic [WORD_W-1:0] chan_in_3;
        logic [WORD_W-1:0] chan_in_4;
        logic [WORD_W-1:0] chan_in_5;
        logic [WORD_W-1:0] chan_in_6;
        logic [WORD_W-1:0] chan_in_7;
    } t_pix_in;

    typedef struct packed {
        logic [WORD_W-1:0] chan_out_0;
        logic [WORD_W-1:0] chan_out_1;
        logic [WORD_W-1:0] chan_out_2;
        logic [WORD_W-1:0] chan_out_3;
        logic [WORD_W-1:0] chan_out_4;
        logic [WORD_W-1:0] chan_out_5;
        logic [WORD_W-1:0] chan_out_6;
        logic [WORD_W-1:0] chan_out_7;
    } t_pix_out;

endpackage

@@ hw/rtl/psd_cfg.sv @@
// Size registers, clamping to the legal range, and restart pulse.
module psd_cfg #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [psd_pkg::IDX_W-1:0]  i_idx,
    input  logic [psd_pkg::CFG_W-1:0]  i_data,
    output psd_pkg::t_sizes            o_sizes,
    output logic                       o_restart
);
    localparam int CW = psd_pkg::CFG_W;
    localparam int CMAX = (1 << CW) - 1;
    localparam logic [CW-1:0] CLAMP = (MAX_SIDE > CMAX) ? CW'(CMAX) : CW'(MAX_SIDE);

    logic [CW-1:0] r_in_h, r_in_w, r_out_h, r_out_w;
    logic          r_restart;

    function automatic logic [CW-1:0] eff(input logic [CW-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (int'(v) > MAX_SIDE) begin
            res = CLAMP;
        end else begin
            res = v;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_h    <= CW'(1);
            r_in_w    <= CW'(1);
            r_out_h   <= CW'(1);
            r_out_w   <= CW'(1);
            r_restart <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_wr) begin
                unique case (i_idx)
                    psd_pkg::REG_IN_HEIGHT: begin
                        r_in_h    <= i_data;
                        r_restart <= 1'b1;
                    end
                    psd_pkg::REG_IN_WIDTH: begin
                        r_in_w    <= i_data;
                        r_restart <= 1'b1;
                    end
                    psd_pkg::REG_OUT_HEIGHT: begin
                        r_out_h   <= i_data;
                        r_restart <= 1'b1;
                    end
                    psd_pkg::REG_OUT_WIDTH: begin
                        r_out_w   <= i_data;
                        r_restart <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_sizes.in_h  = eff(r_in_h);
    assign o_sizes.in_w  = eff(r_in_w);
    assign o_sizes.out_h = eff(r_out_h);
    assign o_sizes.out_w = eff(r_out_w);
    assign o_restart     = r_restart;

endmodule

@@ hw/rtl/psd_div.sv @@
// Iterative restoring divider that forms a stride: 1 + num / den, one bit per cycle.
module psd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [psd_pkg::CFG_W-1:0] i_num,
    input  logic [psd_pkg::CFG_W-1:0] i_den,
    output logic                      o_busy,
    output logic [psd_pkg::CFG_W-1:0] o_step
);
    localparam int W     = psd_pkg::CFG_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_num, r_rem, r_den, r_step;

    logic [W:0]   w_sh, w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem, n_num;

    always_comb begin
        w_sh   = {r_rem, r_num[W-1]};
        w_diff = w_sh - {1'b0, r_den};
        w_ge   = w_sh >= {1'b0, r_den};
        n_rem  = w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
        n_num  = {r_num[W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= W'(1);
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            r_busy <= 1'b0;
            r_step <= n_num + W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(W);
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_step = r_step;

endmodule

@@ hw/rtl/psd_keep.sv @@
// Row and column position, phase and count tracking; keep-or-drop decision per pixel.
module psd_keep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_fire,
    input  psd_pkg::t_sizes           i_sizes,
    input  logic [psd_pkg::CFG_W-1:0] i_row_step,
    input  logic [psd_pkg::CFG_W-1:0] i_col_step,
    output logic                      o_emit
);
    localparam int W = psd_pkg::CFG_W;

    logic [W-1:0] r_row_pos, r_col_pos, r_row_ph, r_col_ph, r_rows_cnt, r_cols_cnt;
    logic [W-1:0] n_row_pos, n_col_pos, n_row_ph, n_col_ph, n_rows_cnt, n_cols_cnt;

    logic [W-1:0] w_half_h, w_half_w, w_short_h, w_short_w;
    logic [W-1:0] w_row_ph_inc, w_col_ph_inc;
    logic         w_row_exact, w_col_exact, w_row_last, w_col_last, w_row_on, w_col_on;
    logic         w_keep_row, w_keep_col;

    always_comb begin
        w_half_h    = W'(1) + ((i_sizes.in_h - W'(1)) >> 1);
        w_half_w    = W'(1) + ((i_sizes.in_w - W'(1)) >> 1);
        w_row_exact = w_half_h >= i_sizes.out_h;
        w_col_exact = w_half_w >= i_sizes.out_w;
        w_short_h   = i_sizes.out_h - w_half_h;
        w_short_w   = i_sizes.out_w - w_half_w;
        w_row_last  = ({1'b0, r_row_pos} + (W+1)'(1)) >= {1'b0, i_sizes.in_h};
        w_col_last  = ({1'b0, r_col_pos} + (W+1)'(1)) >= {1'b0, i_sizes.in_w};
        w_row_on    = r_row_ph == '0;
        w_col_on    = r_col_ph == '0;

        if (w_row_exact) begin
            w_keep_row = w_row_on || (w_row_last && r_rows_cnt < i_sizes.out_h);
        end else begin
            w_keep_row = w_row_on || r_rows_cnt < w_short_h;
        end
        if (w_col_exact) begin
            w_keep_col = w_col_on || (w_col_last && r_cols_cnt < i_sizes.out_w);
        end else begin
            w_keep_col = w_col_on || r_cols_cnt < w_short_w;
        end

        // wrap phases at the stride
        w_row_ph_inc = (({1'b0, r_row_ph} + (W+1)'(1)) >= {1'b0, i_row_step}) ?
                       '0 : r_row_ph + W'(1);
        w_col_ph_inc = (({1'b0, r_col_ph} + (W+1)'(1)) >= {1'b0, i_col_step}) ?
                       '0 : r_col_ph + W'(1);

        // saturate counts at their maximum
        n_cols_cnt = r_cols_cnt;
        n_rows_cnt = r_rows_cnt;
        if (w_keep_row) begin
            if (w_keep_col && (w_col_exact || !w_col_on) && r_cols_cnt != '1) begin
                n_cols_cnt = r_cols_cnt + W'(1);
            end
            if (w_col_last && (w_row_exact || !w_row_on) && r_rows_cnt != '1) begin
                n_rows_cnt = r_rows_cnt + W'(1);
            end
        end

        n_row_pos = r_row_pos;
        n_row_ph  = r_row_ph;
        if (w_col_last) begin
            n_col_pos  = '0;
            n_col_ph   = '0;
            n_cols_cnt = '0;
            if (w_row_last) begin
                n_row_pos  = '0;
                n_row_ph   = '0;
                n_rows_cnt = '0;
            end else begin
                n_row_pos = r_row_pos + W'(1);
                n_row_ph  = w_row_ph_inc;
            end
        end else begin
            n_col_pos = r_col_pos + W'(1);
            n_col_ph  = w_col_ph_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_row_ph   <= '0;
            r_col_ph   <= '0;
            r_rows_cnt <= '0;
            r_cols_cnt <= '0;
        end else if (i_fire) begin
            r_row_pos  <= n_row_pos;
            r_col_pos  <= n_col_pos;
            r_row_ph   <= n_row_ph;
            r_col_ph   <= n_col_ph;
            r_rows_cnt <= n_rows_cnt;
            r_cols_cnt <= n_cols_cnt;
        end
    end

    assign o_emit = w_keep_row && w_keep_col;

endmodule

@@ hw/rtl/psd_obuf.sv @@
// Output register with a skid stage so the input side registers its stall.
module psd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  psd_pkg::t_pix_out i_data,
    input  logic              i_stall,
    output logic              o_valid,
    output psd_pkg::t_pix_out o_data,
    output logic              o_full
);
    logic              r_out_v, r_skid_v;
    psd_pkg::t_pix_out r_out, r_skid;
    logic              w_take;

    assign w_take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // no push while the skid holds an item
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= i_push;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            r_out <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;
    assign o_full  = r_skid_v;

endmodule

@@ hw/rtl/pixel_stream_decimator_top.sv @@
// A kept pixel is registered in the output stage, or first in the skid stage if the output is stalled.
// Throughput: one pixel per cycle while o_stall is low; the keep decision is counters and compares only.
// A size write stalls the input while the restart pulse issues and then while the
// stride dividers iterate (one quotient bit per cycle, both axes at once).
// Reset (synchronous, active low) sets all sizes and strides to one and clears
// positions, phases, counts and the output stages.
module pixel_stream_decimator_top #(
    parameter int CHANNELS = 8,
    parameter int MAX_SIDE = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  psd_pkg::t_pix_in          i_pix,
    output logic                      o_valid,
    input  logic                      i_stall,
    output psd_pkg::t_pix_out         o_pix,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [psd_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [psd_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int W  = psd_pkg::CFG_W;
    localparam int WW = psd_pkg::WORD_W;
    localparam int NC = psd_pkg::NCH_MAX;

    psd_pkg::t_sizes   w_sizes;
    psd_pkg::t_pix_out w_pix_out;
    logic              w_restart, w_row_busy, w_col_busy, w_full, w_fire, w_emit;
    logic [W-1:0]      w_row_step, w_col_step;
    logic [WW-1:0]     w_in [NC];
    logic [WW-1:0]     w_out [NC];

    assign o_cfg_ready = 1'b1;

    psd_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_cfg_valid),
        .i_idx     (i_cfg_idx),
        .i_data    (i_cfg_data),
        .o_sizes   (w_sizes),
        .o_restart (w_restart)
    );

    psd_div u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_restart),
        .i_num   (w_sizes.in_h - W'(1)),
        .i_den   (w_sizes.out_h),
        .o_busy  (w_row_busy),
        .o_step  (w_row_step)
    );

    psd_div u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_restart),
        .i_num   (w_sizes.in_w - W'(1)),
        .i_den   (w_sizes.out_w),
        .o_busy  (w_col_busy),
        .o_step  (w_col_step)
    );

    assign o_stall = w_restart || w_row_busy || w_col_busy || w_full;
    assign w_fire  = i_valid && !o_stall;

    psd_keep u_keep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_restart),
        .i_fire     (w_fire),
        .i_sizes    (w_sizes),
        .i_row_step (w_row_step),
        .i_col_step (w_col_step),
        .o_emit     (w_emit)
    );

    assign w_in[0] = i_pix.chan_in_0;
    assign w_in[1] = i_pix.chan_in_1;
    assign w_in[2] = i_pix.chan_in_2;
    assign w_in[3] = i_pix.chan_in_3;
    assign w_in[4] = i_pix.chan_in_4;
    assign w_in[5] = i_pix.chan_in_5;
    assign w_in[6] = i_pix.chan_in_6;
    assign w_in[7] = i_pix.chan_in_7;

    // zero the channels beyond the configured count
    for (genvar j = 0; j < NC; j++) begin : g_chan
        if (j < CHANNELS) begin : g_used
            assign w_out[j] = w_in[j];
        end else begin : g_unused
            assign w_out[j] = '0;
        end
    end

    assign w_pix_out.chan_out_0 = w_out[0];
    assign w_pix_out.chan_out_1 = w_out[1];
    assign w_pix_out.chan_out_2 = w_out[2];
    assign w_pix_out.chan_out_3 = w_out[3];
    assign w_pix_out.chan_out_4 = w_out[4];
    assign w_pix_out.chan_out_5 = w_out[5];
    assign w_pix_out.chan_out_6 = w_out[6];
    assign w_pix_out.chan_out_7 = w_out[7];

    psd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire && w_emit),
        .i_data  (w_pix_out),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_pix),
        .o_full  (w_full)
    );

endmodule
